### hdl/pct_pkg.sv
package pct_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PSCAN,
        S_PWRITE,
        S_CSCAN,
        S_CWRITE,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        CM_WRITE,
        CM_KILL_ONE,
        CM_KILL_OWNER
    } cmode_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] pid;
        logic [31:0] child_pid;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] answer_pid;
    } rsp_t;

    typedef struct packed {
        logic        shift;
        logic        tail_valid;
    } ring_ctl_t;

endpackage

### hdl/pct_cell.sv
module pct_cell
    import pct_pkg::*;
#(
    parameter int W = 48
)(
    input  logic         clk,
    input  logic         rst_n,
    input  ring_ctl_t    ctl,
    input  logic         valid_in,
    input  logic [W-1:0] data_in,
    output logic         valid_q,
    output logic [W-1:0] data_q
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= data_in;
        end
    end

    assign valid_q = valid_reg;
    assign data_q  = data_reg;

endmodule

### hdl/process_parent_child_table_core.sv
// Process parent/child table.
// Input channel: in_valid/in_stall carry one request word (operation, pid,
// child_pid). Output channel: out_valid/out_stall carry one response word
// (status, found, answer_pid) per request.
// Parents and children sit in two rings of cells that rotate one slot per
// cycle while an operation runs; the controller works on the head cell.
// Passes per request (each a full ring turn), then the result step:
//   parent scan only: find of a parent, failed insert, add to unknown parent
//   parent scan, parent write: insert parent; plus child write: remove parent
//   parent, child scan: find child; plus child write: add child, remove child
// One request is in work at a time; in_stall is high from acceptance until
// the response moves to the output register, which may still hold the
// previous response while the next request is accepted.
// When out_stall is high the response is held; a finished request waits
// for the output register to empty.
// Reset empties both tables and clears the insertion counter; no clearing
// pass is needed.
module process_parent_child_table_core
    import pct_pkg::*;
#(
    parameter int PARENT_SLOTS = 16,
    parameter int CHILD_SLOTS  = 64
)(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_word,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t out_word
);

    localparam int PW  = (PARENT_SLOTS > 1) ? $clog2(PARENT_SLOTS) : 1;
    localparam int CW  = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;
    localparam int PDW = 48;
    localparam int CDW = 32 + PW + 16 + 32;

    logic           pv [PARENT_SLOTS];
    logic [PDW-1:0] pd [PARENT_SLOTS];
    logic           cv [CHILD_SLOTS];
    logic [CDW-1:0] cd [CHILD_SLOTS];

    ring_ctl_t      p_ctl, c_ctl;
    logic [PDW-1:0] p_tail;
    logic [CDW-1:0] c_tail;

    genvar g;
    generate
        for (g = 0; g < PARENT_SLOTS; g++)
        begin : g_par
            if (g == PARENT_SLOTS - 1)
            begin : g_last
                pct_cell #(.W(PDW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .ctl(p_ctl),
                    .valid_in(p_ctl.tail_valid), .data_in(p_tail),
                    .valid_q(pv[g]), .data_q(pd[g])
                );
            end
            else
            begin : g_mid
                pct_cell #(.W(PDW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .ctl(p_ctl),
                    .valid_in(pv[g+1]), .data_in(pd[g+1]),
                    .valid_q(pv[g]), .data_q(pd[g])
                );
            end
        end
        for (g = 0; g < CHILD_SLOTS; g++)
        begin : g_chd
            if (g == CHILD_SLOTS - 1)
            begin : g_last
                pct_cell #(.W(CDW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .ctl(c_ctl),
                    .valid_in(c_ctl.tail_valid), .data_in(c_tail),
                    .valid_q(cv[g]), .data_q(cd[g])
                );
            end
            else
            begin : g_mid
                pct_cell #(.W(CDW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .ctl(c_ctl),
                    .valid_in(cv[g+1]), .data_in(cd[g+1]),
                    .valid_q(cv[g]), .data_q(cd[g])
                );
            end
        end
    endgenerate

    state_t      state_reg, state_next;
    req_t        job_reg, job_next;
    logic [PW-1:0] pk_reg, pk_next;
    logic [CW-1:0] ck_reg, ck_next;
    logic        p_hit_reg, p_hit_next;
    logic [PW-1:0] p_idx_reg, p_idx_next;
    logic [15:0] p_age_reg, p_age_next;
    logic        pf_hit_reg, pf_hit_next;
    logic [PW-1:0] pf_idx_reg, pf_idx_next;
    logic        c_dup_reg, c_dup_next;
    logic        cf_hit_reg, cf_hit_next;
    logic [CW-1:0] cf_idx_reg, cf_idx_next;
    logic        cb_hit_reg, cb_hit_next;
    logic [CW-1:0] cb_idx_reg, cb_idx_next;
    logic [15:0] cb_d_reg, cb_d_next;
    logic [31:0] cb_oid_reg, cb_oid_next;
    logic [CW-1:0] c_tgt_reg, c_tgt_next;
    cmode_t      cmode_reg, cmode_next;
    logic [15:0] ctr_reg, ctr_next;
    rsp_t        res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_word_reg, out_word_next;

    logic [31:0] h_pid;
    logic [15:0] h_page;
    logic [31:0] h_cid;
    logic [PW-1:0] h_cown;
    logic [15:0] h_coage;
    logic [31:0] h_coid;
    logic [15:0] h_dist;
    logic        p_last, c_last;

    assign {h_pid, h_page}                = pd[0];
    assign {h_cid, h_cown, h_coage, h_coid} = cd[0];
    assign h_dist = ctr_reg - h_coage;
    assign p_last = (pk_reg == PW'(PARENT_SLOTS - 1));
    assign c_last = (ck_reg == CW'(CHILD_SLOTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        pk_reg       <= pk_next;
        ck_reg       <= ck_next;
        p_hit_reg    <= p_hit_next;
        p_idx_reg    <= p_idx_next;
        p_age_reg    <= p_age_next;
        pf_hit_reg   <= pf_hit_next;
        pf_idx_reg   <= pf_idx_next;
        c_dup_reg    <= c_dup_next;
        cf_hit_reg   <= cf_hit_next;
        cf_idx_reg   <= cf_idx_next;
        cb_hit_reg   <= cb_hit_next;
        cb_idx_reg   <= cb_idx_next;
        cb_d_reg     <= cb_d_next;
        cb_oid_reg   <= cb_oid_next;
        c_tgt_reg    <= c_tgt_next;
        cmode_reg    <= cmode_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        pk_next        = pk_reg;
        ck_next        = ck_reg;
        p_hit_next     = p_hit_reg;
        p_idx_next     = p_idx_reg;
        p_age_next     = p_age_reg;
        pf_hit_next    = pf_hit_reg;
        pf_idx_next    = pf_idx_reg;
        c_dup_next     = c_dup_reg;
        cf_hit_next    = cf_hit_reg;
        cf_idx_next    = cf_idx_reg;
        cb_hit_next    = cb_hit_reg;
        cb_idx_next    = cb_idx_reg;
        cb_d_next      = cb_d_reg;
        cb_oid_next    = cb_oid_reg;
        c_tgt_next     = c_tgt_reg;
        cmode_next     = cmode_reg;
        ctr_next       = ctr_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        p_ctl          = '{shift: 1'b0, tail_valid: pv[0]};
        c_ctl          = '{shift: 1'b0, tail_valid: cv[0]};
        p_tail         = pd[0];
        c_tail         = cd[0];
        in_stall       = (state_reg != S_IDLE);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    job_next    = in_word;
                    pk_next     = '0;
                    ck_next     = '0;
                    p_hit_next  = 1'b0;
                    pf_hit_next = 1'b0;
                    c_dup_next  = 1'b0;
                    cf_hit_next = 1'b0;
                    cb_hit_next = 1'b0;
                    res_next    = '{status: ST_DONE, found: 1'b0, answer_pid: '0};
                    state_next  = S_PSCAN;
                end
            end
            S_PSCAN:
            begin
                p_ctl.shift = 1'b1;
                if (pv[0] && h_pid == job_reg.pid && !p_hit_reg)
                begin
                    p_hit_next = 1'b1;
                    p_idx_next = pk_reg;
                    p_age_next = h_page;
                end
                if (!pv[0] && !pf_hit_reg)
                begin
                    pf_hit_next = 1'b1;
                    pf_idx_next = pk_reg;
                end
                pk_next = pk_reg + 1'b1;
                if (p_last)
                begin
                    pk_next = '0;
                    unique case (op_t'(job_reg.operation))
                        OP_INSERT:
                        begin
                            if (p_hit_next)
                            begin
                                res_next.status = ST_PRESENT;
                                state_next = S_RESULT;
                            end
                            else if (!pf_hit_next)
                            begin
                                res_next.status = ST_FULL;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_PWRITE;
                            end
                        end
                        OP_ADD:
                        begin
                            if (!p_hit_next)
                            begin
                                res_next.status = ST_NOT_FOUND;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_CSCAN;
                            end
                        end
                        OP_REMOVE:
                        begin
                            state_next = p_hit_next ? S_PWRITE : S_CSCAN;
                        end
                        OP_FIND:
                        begin
                            if (p_hit_next)
                            begin
                                res_next.found      = 1'b1;
                                res_next.answer_pid = job_reg.pid;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_CSCAN;
                            end
                        end
                    endcase
                end
            end
            S_PWRITE:
            begin
                p_ctl.shift = 1'b1;
                if (op_t'(job_reg.operation) == OP_INSERT)
                begin
                    if (pk_reg == pf_idx_reg)
                    begin
                        p_ctl.tail_valid = 1'b1;
                        p_tail = {job_reg.pid, ctr_reg};
                    end
                end
                else if (pk_reg == p_idx_reg)
                begin
                    p_ctl.tail_valid = 1'b0;
                end
                pk_next = pk_reg + 1'b1;
                if (p_last)
                begin
                    pk_next = '0;
                    if (op_t'(job_reg.operation) == OP_INSERT)
                    begin
                        ctr_next   = ctr_reg + 16'd1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmode_next = CM_KILL_OWNER;
                        ck_next    = '0;
                        state_next = S_CWRITE;
                    end
                end
            end
            S_CSCAN:
            begin
                c_ctl.shift = 1'b1;
                if (cv[0] && h_cown == p_idx_reg && h_cid == job_reg.child_pid)
                begin
                    c_dup_next = 1'b1;
                end
                if (!cv[0] && !cf_hit_reg)
                begin
                    cf_hit_next = 1'b1;
                    cf_idx_next = ck_reg;
                end
                if (cv[0] && h_cid == job_reg.pid && (!cb_hit_reg || h_dist < cb_d_reg))
                begin
                    cb_hit_next = 1'b1;
                    cb_idx_next = ck_reg;
                    cb_d_next   = h_dist;
                    cb_oid_next = h_coid;
                end
                ck_next = ck_reg + 1'b1;
                if (c_last)
                begin
                    ck_next = '0;
                    priority case (op_t'(job_reg.operation))
                        OP_ADD:
                        begin
                            if (c_dup_next)
                            begin
                                res_next.status = ST_PRESENT;
                                state_next = S_RESULT;
                            end
                            else if (!cf_hit_next)
                            begin
                                res_next.status = ST_FULL;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                cmode_next = CM_WRITE;
                                c_tgt_next = cf_idx_next;
                                state_next = S_CWRITE;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cb_hit_next)
                            begin
                                cmode_next = CM_KILL_ONE;
                                c_tgt_next = cb_idx_next;
                                state_next = S_CWRITE;
                            end
                            else
                            begin
                                res_next.status = ST_NOT_FOUND;
                                state_next = S_RESULT;
                            end
                        end
                        default:
                        begin
                            if (cb_hit_next)
                            begin
                                res_next.found      = 1'b1;
                                res_next.answer_pid = cb_oid_next;
                            end
                            else
                            begin
                                res_next.status = ST_NOT_FOUND;
                            end
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_CWRITE:
            begin
                c_ctl.shift = 1'b1;
                unique case (cmode_reg)
                    CM_WRITE:
                    begin
                        if (ck_reg == c_tgt_reg)
                        begin
                            c_ctl.tail_valid = 1'b1;
                            c_tail = {job_reg.child_pid, p_idx_reg, p_age_reg, job_reg.pid};
                        end
                    end
                    CM_KILL_ONE:
                    begin
                        if (ck_reg == c_tgt_reg)
                        begin
                            c_ctl.tail_valid = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (h_cown == p_idx_reg)
                        begin
                            c_ctl.tail_valid = 1'b0;
                        end
                    end
                endcase
                ck_next = ck_reg + 1'b1;
                if (c_last)
                begin
                    ck_next = '0;
                    if (cmode_reg == CM_WRITE)
                    begin
                        ctr_next = ctr_reg + 16'd1;
                    end
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pct_pkg::*;

    localparam int PSLOTS = 16;
    localparam int CSLOTS = 64;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_word;
    logic out_valid;
    logic out_stall;
    rsp_t out_word;

    process_parent_child_table_core #(
        .PARENT_SLOTS(PSLOTS),
        .CHILD_SLOTS (CSLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word)
    );

    // table shadow
    logic        par_used [PSLOTS] = '{default: 1'b0};
    logic [31:0] par_pid  [PSLOTS];
    logic [15:0] par_age  [PSLOTS];
    logic        kid_used [CSLOTS] = '{default: 1'b0};
    logic [31:0] kid_pid  [CSLOTS];
    int          kid_owner[CSLOTS];
    logic [15:0] stamp_ctr = '0;

    req_t pending_words[$];
    rsp_t expected_rsp[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_recv = 0;
    bit   hold_go = 1'b0;
    bit   send_pause;
    int   errors = 0;
    int   rsp_seen = 0;
    int   op_count[4] = '{default: 0};
    int   st_count[4] = '{default: 0};
    logic [31:0] known_ids[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #80ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    // hold the receiver off for a long stretch
    initial
    begin
        wait (hold_go);
        for (int i = 3000; i > 0; i--)
        begin
            hold_recv <= i;
            @(posedge clk);
        end
        hold_recv <= 0;
    end

    function automatic int parent_slot(logic [31:0] id);
        for (int i = 0; i < PSLOTS; i++)
            if (par_used[i] && par_pid[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int newest_child(logic [31:0] id);
        int best;
        logic [15:0] best_d;
        logic [15:0] d;
        best = -1;
        best_d = '0;
        for (int i = 0; i < CSLOTS; i++)
        begin
            if (kid_used[i] && kid_pid[i] == id)
            begin
                d = stamp_ctr - par_age[kid_owner[i]];
                if (best < 0 || d < best_d)
                begin
                    best = i;
                    best_d = d;
                end
            end
        end
        return best;
    endfunction

    function automatic rsp_t apply_table_op(req_t w);
        rsp_t r;
        int p;
        int c;
        int f;
        bit dup;
        r.status = ST_DONE;
        r.found = 1'b0;
        r.answer_pid = '0;
        p = parent_slot(w.pid);
        case (op_t'(w.operation))
            OP_INSERT:
            begin
                f = -1;
                for (int i = PSLOTS - 1; i >= 0; i--)
                    if (!par_used[i])
                        f = i;
                if (p >= 0)
                    r.status = ST_PRESENT;
                else if (f < 0)
                    r.status = ST_FULL;
                else
                begin
                    par_used[f] = 1'b1;
                    par_pid[f] = w.pid;
                    par_age[f] = stamp_ctr;
                    stamp_ctr++;
                end
            end
            OP_ADD:
            begin
                if (p < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    dup = 1'b0;
                    f = -1;
                    for (int i = CSLOTS - 1; i >= 0; i--)
                    begin
                        if (kid_used[i] && kid_owner[i] == p && kid_pid[i] == w.child_pid)
                            dup = 1'b1;
                        if (!kid_used[i])
                            f = i;
                    end
                    if (dup)
                        r.status = ST_PRESENT;
                    else if (f < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        kid_used[f] = 1'b1;
                        kid_pid[f] = w.child_pid;
                        kid_owner[f] = p;
                        stamp_ctr++;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (p >= 0)
                begin
                    par_used[p] = 1'b0;
                    for (int i = 0; i < CSLOTS; i++)
                        if (kid_used[i] && kid_owner[i] == p)
                            kid_used[i] = 1'b0;
                end
                else
                begin
                    c = newest_child(w.pid);
                    if (c >= 0)
                        kid_used[c] = 1'b0;
                    else
                        r.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                if (p >= 0)
                begin
                    r.found = 1'b1;
                    r.answer_pid = w.pid;
                end
                else
                begin
                    c = newest_child(w.pid);
                    if (c >= 0)
                    begin
                        r.found = 1'b1;
                        r.answer_pid = par_pid[kid_owner[c]];
                    end
                    else
                        r.status = ST_NOT_FOUND;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_id();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7 && known_ids.size() > 0)
            return known_ids[$urandom_range(0, known_ids.size() - 1)];
        if (k == 7)
            return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    task automatic queue_word(op_t op, logic [31:0] pid, logic [31:0] cpid);
        req_t w;
        w.operation = op;
        w.pid = pid;
        w.child_pid = cpid;
        pending_words.push_back(w);
    endtask

    task automatic queue_random(int n);
        int k;
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            a = pick_id();
            b = pick_id();
            if (known_ids.size() < 40 && $urandom_range(0, 3) == 0)
            begin
                known_ids.push_back(a);
                known_ids.push_back(b);
            end
            if (k < 20)
                queue_word(OP_INSERT, a, $urandom());
            else if (k < 50)
                queue_word(OP_ADD, a, b);
            else if (k < 70)
                queue_word(OP_REMOVE, a, $urandom());
            else
                queue_word(OP_FIND, a, $urandom());
            if ($urandom_range(0, 199) == 0)
                known_ids.delete();
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_rsp.size() > 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_rsp.push_back(apply_table_op(in_word));
                op_count[in_word.operation]++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() > 0 && !send_pause &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_word <= pending_words.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                rsp_seen++;
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected response %p", $time, out_word);
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsp.pop_front();
                    st_count[e.status]++;
                    if (out_word.status !== e.status || out_word.found !== e.found ||
                        out_word.answer_pid !== e.answer_pid)
                    begin
                        errors++;
                        $display("%0t mismatch expected %p actual %p", $time, e, out_word);
                    end
                end
            end
            if (hold_recv > 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        int guard;
        send_pause = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 65;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // edges: empty table, zero and all-ones ids, duplicates, full parents
        queue_word(OP_FIND, 32'h0, 32'h0);
        queue_word(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
        queue_word(OP_ADD, 32'h0, 32'h1);
        queue_word(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
        queue_word(OP_INSERT, 32'h0, 32'h0);
        queue_word(OP_FIND, 32'h0, 32'h0);
        queue_word(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        queue_word(OP_ADD, 32'h0, 32'hFFFF_FFFF);
        queue_word(OP_ADD, 32'h0, 32'hFFFF_FFFF);
        queue_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(OP_FIND, 32'hFFFF_FFFF, 32'h0);
        queue_word(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
        queue_word(OP_FIND, 32'hFFFF_FFFF, 32'h0);
        queue_word(OP_REMOVE, 32'h0, 32'h0);
        for (int i = 1; i <= 17; i++)
            queue_word(OP_INSERT, 32'hA5A5_0000 + i, 32'h0);
        for (int i = 1; i <= 17; i++)
            queue_word(OP_REMOVE, 32'hA5A5_0000 + i, 32'h0);

        // fill the child store, then overflow it
        for (int i = 0; i < 4; i++)
            queue_word(OP_INSERT, 32'h100 + i, 32'h0);
        for (int i = 0; i < 66; i++)
            queue_word(OP_ADD, 32'h100 + (i % 4), 32'h5000 + (i / 4));
        queue_word(OP_FIND, 32'h5000, 32'h0);
        queue_word(OP_REMOVE, 32'h5000, 32'h0);
        queue_word(OP_FIND, 32'h5000, 32'h0);
        for (int i = 0; i < 4; i++)
            queue_word(OP_REMOVE, 32'h100 + i, 32'h0);

        // receiver holds off while words keep arriving
        hold_go = 1'b1;
        queue_random(350);
        wait_drained();

        send_pause = 1'b1;
        repeat (50) @(posedge clk);
        send_pause = 1'b0;

        send_idle_pct = 65;
        recv_idle_pct = 22;
        queue_random(350);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(350);
        wait_drained();

        guard = 0;
        while (!out_valid && guard < 400)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        $display("ops insert/add/remove/find: %0d/%0d/%0d/%0d, responses %0d",
                 op_count[OP_INSERT], op_count[OP_ADD], op_count[OP_REMOVE],
                 op_count[OP_FIND], rsp_seen);
        $display("status done/present/not found/full: %0d/%0d/%0d/%0d",
                 st_count[ST_DONE], st_count[ST_PRESENT], st_count[ST_NOT_FOUND],
                 st_count[ST_FULL]);
        if (errors == 0 && expected_rsp.size() == 0 && !out_valid)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
